// File: rtl/core/mf3_pkg.sv
package mf3_pkg;

  // Result field widths
  localparam int VALUE_W  = 8;
  localparam int ROW_W    = 12;
  localparam int COLUMN_W = 10;

  // Configuration register indexes
  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  localparam int CFG_DATA_W     = 13;
  localparam int ROW_COUNT_W    = 13;
  localparam int COLUMN_COUNT_W = 11;

  // Frame size limits and reset values
  localparam int ROW_MIN            = 3;
  localparam int ROW_MAX            = 4096;
  localparam int COLUMN_MIN         = 3;
  localparam int ROW_COUNT_RESET    = 4;
  localparam int COLUMN_COUNT_RESET = 5;

  // Median-of-nine exchange network: after each step the MED_LO slot holds the minimum
  localparam int MED_STEPS = 19;
  localparam logic [3:0] MED_LO [MED_STEPS] = '{
    4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
    4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
  };
  localparam logic [3:0] MED_HI [MED_STEPS] = '{
    4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
    4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
  };
  localparam logic [3:0] MED_MID = 4'd4;

  // One result item
  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [ROW_W-1:0]    row;
    logic [COLUMN_W-1:0] column;
    logic                run_last;
    logic                frame_last;
  } res_t;

endpackage

// File: rtl/core/mf3_median9.sv
module mf3_median9 #(
  parameter int PIXEL_BITS = 8
) (
  input  logic [PIXEL_BITS-1:0] win [9],
  output logic [PIXEL_BITS-1:0] median
);
  import mf3_pkg::*;

  logic [PIXEL_BITS-1:0] p [9];
  logic [PIXEL_BITS-1:0] t;

  // Fixed exchange network, median ends up in the centre slot
  always_comb begin
    p = win;
    t = '0;
    for (int k = 0; k < MED_STEPS; k++) begin
      if (p[MED_LO[k]] > p[MED_HI[k]]) begin
        t = p[MED_LO[k]];
        p[MED_LO[k]] = p[MED_HI[k]];
        p[MED_HI[k]] = t;
      end
    end
    median = p[MED_MID];
  end

endmodule

// File: rtl/core/median_filter_3x3_top.sv
// Channel  | Dir | Payload                                   | Handshake
// s_*      | in  | tdata[7:0] pixel                          | s_tvalid/s_tready
// m_*      | out | tdata: value, row, column; tuser run_last; | m_tvalid/m_tready
//          |     | tlast frame_last                          |
// cfg_*    | in  | cfg_index selects register, cfg_data      | cfg_write, no wait
//
// A pixel is accepted every cycle as long as its results drain; it is registered in
// stage 1, then in the result slots. Results leave one per cycle while m_tready is
// high, so a pixel causing two or three results (last row or last column) stalls
// the input until they drain. Median: registered line-store read plus one network pass.
// Reset (rst, synchronous) clears positions, pipeline and frame size (4 x 5);
// the line stores are not cleared: every entry is rewritten in a row before a
// median reads it. A configuration write restarts the frame at row 0, column 0.
module median_filter_3x3_top #(
  parameter int MAX_COLUMNS = 1024,
  parameter int PIXEL_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] value, [19:8] row, [29:20] column, [31:30] zero
  output logic        m_tlast,   // frame_last
  output logic        m_tuser,   // [0] run_last
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  import mf3_pkg::*;

  localparam int CB = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RESET_COLS = (COLUMN_COUNT_RESET > MAX_COLUMNS) ? MAX_COLUMNS
                                                                  : COLUMN_COUNT_RESET;

  // Frame size, stored as last index
  logic [ROW_W-1:0] last_row;
  logic [CB-1:0]    last_col;
  logic [31:0]      rows_eff;
  logic [31:0]      cols_eff;

  // Input position
  logic [ROW_W-1:0] row_pos;
  logic [CB-1:0]    col_pos;

  // Line stores: upper row in the high half, middle row in the low half
  logic [2*PIXEL_BITS-1:0] line_mem [MAX_COLUMNS];
  logic [2*PIXEL_BITS-1:0] rd;

  // Stage 1
  logic                  s1_valid;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic [ROW_W-1:0]      s1_row;
  logic [CB-1:0]         s1_col;
  logic                  s1_adv;

  // Window, row-major, column 2 newest
  logic [PIXEL_BITS-1:0] win      [3][3];
  logic [PIXEL_BITS-1:0] win_next [3][3];
  logic [PIXEL_BITS-1:0] med_in   [9];
  logic [PIXEL_BITS-1:0] median;

  // Result slots
  res_t       slot      [3];
  res_t       slot_next [3];
  logic [2:0] mask;
  logic [2:0] mask_next;
  logic [2:0] pop_bit;
  res_t       out_res;

  logic accept;
  logic r_ge1, r_ge2, c_ge1, c_ge2, is_last_row, is_last_col;

  assign accept = s_tvalid && s_tready;

  // Clamp configured frame size
  always_comb begin
    rows_eff = 32'(cfg_data[ROW_COUNT_W-1:0]);
    if (rows_eff < 32'(ROW_MIN)) rows_eff = 32'(ROW_MIN);
    if (rows_eff > 32'(ROW_MAX)) rows_eff = 32'(ROW_MAX);
    cols_eff = 32'(cfg_data[COLUMN_COUNT_W-1:0]);
    if (cols_eff < 32'(COLUMN_MIN)) cols_eff = 32'(COLUMN_MIN);
    if (cols_eff > 32'(MAX_COLUMNS)) cols_eff = 32'(MAX_COLUMNS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_row <= ROW_W'(ROW_COUNT_RESET - 1);
      last_col <= CB'(RESET_COLS - 1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_COUNT:    last_row <= ROW_W'(rows_eff - 32'd1);
        REG_COLUMN_COUNT: last_col <= CB'(cols_eff - 32'd1);
        default:          ;
      endcase
    end
  end

  // Raster position, restarted by any register write
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      if (col_pos == last_col) begin
        col_pos <= '0;
        row_pos <= (row_pos == last_row) ? '0 : row_pos + 1'b1;
      end else begin
        col_pos <= col_pos + 1'b1;
      end
    end
  end

  // Line store: read at acceptance, write back when the item leaves stage 1
  always_ff @(posedge clk) begin
    if (accept) rd <= line_mem[col_pos];
    if (s1_adv) line_mem[s1_col] <= {rd[PIXEL_BITS-1:0], s1_pix};
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= PIXEL_BITS'(s_tdata);
      s1_row <= row_pos;
      s1_col <= col_pos;
    end
  end

  // Stage 1 leaves when the result slots are empty or drain this cycle
  assign s1_adv   = s1_valid && ((mask == 3'b000) ||
                    (((mask & (mask - 3'd1)) == 3'b000) && m_tready));
  assign s_tready = !s1_valid || s1_adv;

  // Window shifted by one column
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i][0] = win[i][1];
      win_next[i][1] = win[i][2];
    end
    win_next[0][2] = rd[2*PIXEL_BITS-1:PIXEL_BITS];
    win_next[1][2] = rd[PIXEL_BITS-1:0];
    win_next[2][2] = s1_pix;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        med_in[3*i+j] = win_next[i][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) win <= win_next;
  end

  mf3_median9 #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_median (
    .win    (med_in),
    .median (median)
  );

  // Results caused by the stage 1 pixel
  assign r_ge1       = (s1_row != '0);
  assign r_ge2       = (s1_row > ROW_W'(1));
  assign c_ge1       = (s1_col != '0);
  assign c_ge2       = (s1_col > CB'(1));
  assign is_last_row = (s1_row == last_row);
  assign is_last_col = (s1_col == last_col);

  always_comb begin
    mask_next[0] = r_ge1 && c_ge1;
    mask_next[1] = r_ge1 && is_last_col;
    mask_next[2] = is_last_row;

    // Pixel above-left: median inside, original on the border
    slot_next[0].value      = VALUE_W'((r_ge2 && c_ge2) ? median : win_next[1][1]);
    slot_next[0].row        = s1_row - 1'b1;
    slot_next[0].column     = COLUMN_W'(s1_col - CB'(1));
    slot_next[0].run_last   = !mask_next[1] && !mask_next[2];
    slot_next[0].frame_last = 1'b0;

    // Pixel above, last column
    slot_next[1].value      = VALUE_W'(win_next[1][2]);
    slot_next[1].row        = s1_row - 1'b1;
    slot_next[1].column     = COLUMN_W'(s1_col);
    slot_next[1].run_last   = !mask_next[2];
    slot_next[1].frame_last = 1'b0;

    // Current pixel, last row
    slot_next[2].value      = VALUE_W'(s1_pix);
    slot_next[2].row        = s1_row;
    slot_next[2].column     = COLUMN_W'(s1_col);
    slot_next[2].run_last   = 1'b1;
    slot_next[2].frame_last = is_last_col;
  end

  // Output slots, lowest valid slot goes first
  assign pop_bit = mask & (~mask + 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (s1_adv) begin
      mask <= mask_next;
    end else if (m_tvalid && m_tready) begin
      mask <= mask & ~pop_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) slot <= slot_next;
  end

  always_comb begin
    if (mask[0]) begin
      out_res = slot[0];
    end else if (mask[1]) begin
      out_res = slot[1];
    end else begin
      out_res = slot[2];
    end
  end

  assign m_tvalid = (mask != 3'b000);
  assign m_tdata  = {2'b00, out_res.column, out_res.row, out_res.value};
  assign m_tlast  = out_res.frame_last;
  assign m_tuser  = out_res.run_last;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mf3_pkg::*;

  localparam int MAX_COLUMNS = 1024;

  // stimulus styles for pixel content
  typedef enum int {PIX_ANY, PIX_NEAR, PIX_EXTREME} pix_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;      // [7:0] pixel
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [7:0] value, [19:8] row, [29:20] column, [31:30] zero
  logic        m_tlast;           // frame_last
  logic        m_tuser;           // [0] run_last
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [12:0] cfg_data = '0;

  // predictor state
  logic [7:0]                upper_line [MAX_COLUMNS];
  logic [7:0]                middle_line [MAX_COLUMNS];
  logic [7:0]                win [3][3];
  int unsigned               row_pos;
  int unsigned               col_pos;
  logic [ROW_COUNT_W-1:0]    rows_reg;
  logic [COLUMN_COUNT_W-1:0] cols_reg;

  res_t        due_pixels [$];
  res_t        want;
  int unsigned bad_pixels = 0;
  bit          calm = 1'b0;

  median_filter_3x3_top #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .PIXEL_BITS (8)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // sink side back-pressure
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 14);
  end

  // frame size as the block sees it
  function automatic int unsigned active_rows();
    int unsigned rows;
    rows = rows_reg;
    if (rows < ROW_MIN) rows = ROW_MIN;
    if (rows > ROW_MAX) rows = ROW_MAX;
    return rows;
  endfunction

  function automatic int unsigned active_columns();
    int unsigned cols;
    cols = cols_reg;
    if (cols < COLUMN_MIN) cols = COLUMN_MIN;
    if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
    return cols;
  endfunction

  function automatic void clear_filter();
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i / 3][i % 3] = '0;
    row_pos = 0;
    col_pos = 0;
    rows_reg = ROW_COUNT_RESET;
    cols_reg = COLUMN_COUNT_RESET;
  endfunction

  // insertion sort of the nine window pixels, middle one returned
  function automatic logic [7:0] window_median();
    logic [7:0] v [9];
    logic [7:0] t;
    int         j;
    for (int i = 0; i < 9; i++) v[i] = win[i / 3][i % 3];
    for (int i = 1; i < 9; i++) begin
      t = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > t) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = t;
    end
    return v[4];
  endfunction

  function automatic res_t make_res(input logic [7:0] pix_val, input int unsigned r,
                                    input int unsigned c);
    res_t res;
    res.value      = pix_val;
    res.row        = r[ROW_W-1:0];
    res.column     = c[COLUMN_W-1:0];
    res.run_last   = 1'b0;
    res.frame_last = 1'b0;
    return res;
  endfunction

  // advance the filter by one pixel and queue the results it releases
  function automatic void filter_pixel(input logic [7:0] pix);
    int unsigned rows, cols, r, c, n;
    res_t        found [3];
    rows = active_rows();
    cols = active_columns();
    r = row_pos;
    c = col_pos;
    n = 0;
    if (c >= cols) c = 0;
    if (r >= rows) r = 0;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = upper_line[c];
    win[1][2] = middle_line[c];
    win[2][2] = pix;
    upper_line[c] = middle_line[c];
    middle_line[c] = pix;
    // previous row, one column behind
    if (r >= 1 && c >= 1) begin
      found[n] = make_res((r >= 2 && c >= 2) ? window_median() : win[1][1], r - 1, c - 1);
      n++;
    end
    // right border of the previous row
    if (r >= 1 && c == cols - 1) begin
      found[n] = make_res(win[1][2], r - 1, c);
      n++;
    end
    // bottom border goes straight out
    if (r == rows - 1) begin
      found[n] = make_res(pix, r, c);
      n++;
    end
    if (n > 0) begin
      found[n - 1].run_last = 1'b1;
      if (r == rows - 1 && c == cols - 1) found[n - 1].frame_last = 1'b1;
    end
    for (int i = 0; i < n; i++) due_pixels.push_back(found[i]);
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (due_pixels.size() == 0) begin
        bad_pixels++;
        if (bad_pixels <= 10)
          $display("unexpected result: tdata=%h tuser=%b tlast=%b", m_tdata, m_tuser, m_tlast);
      end else begin
        want = due_pixels.pop_front();
        if (m_tdata[7:0] !== want.value || m_tdata[19:8] !== want.row ||
            m_tdata[29:20] !== want.column || m_tdata[31:30] !== 2'b00 ||
            m_tuser !== want.run_last || m_tlast !== want.frame_last) begin
          bad_pixels++;
          if (bad_pixels <= 10)
            $display({"mismatch: expected value %0d row %0d column %0d run_last %b ",
                      "frame_last %b; got value %0d row %0d column %0d pad %b run_last %b ",
                      "frame_last %b"},
                     want.value, want.row, want.column, want.run_last, want.frame_last,
                     m_tdata[7:0], m_tdata[19:8], m_tdata[29:20], m_tdata[31:30],
                     m_tuser, m_tlast);
        end
      end
    end
  end

  // one pixel item, with an occasional gap in front; called and left at a falling edge
  task automatic send_pixel(input logic [7:0] pix);
    int gap;
    if (!calm && $urandom_range(99) < 6) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    do @(posedge clk); while (!s_tready);
    filter_pixel(pix);
    @(negedge clk);
  endtask

  // stop sending, wait for every due result, then some quiet cycles
  task automatic settle(input int extra);
    s_tvalid <= 1'b0;
    do @(negedge clk); while (due_pixels.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [12:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_ROW_COUNT) rows_reg = data[ROW_COUNT_W-1:0];
    else cols_reg = data[COLUMN_COUNT_W-1:0];
    row_pos = 0;
    col_pos = 0;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_pixel(input pix_style_t style, input logic [7:0] base);
    case (style)
      PIX_NEAR:    return base + 8'($urandom_range(0, 3));
      PIX_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
      default:     return 8'($urandom);
    endcase
  endfunction

  // reset frame size, pixel extremes and alternating bits
  task automatic test_default_frame();
    logic [7:0] pattern [20] = '{
      8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
      8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
      8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F,
      8'hFE, 8'h02, 8'h40, 8'h03, 8'hC8
    };
    for (int i = 0; i < 20; i++) send_pixel(pattern[i]);
    settle(12);
  endtask

  // smallest frame, and sizes below the minimum acting as the minimum
  task automatic test_small_frames();
    write_register(REG_ROW_COUNT, 13'd3);
    write_register(REG_COLUMN_COUNT, 13'd3);
    for (int i = 0; i < 9; i++) send_pixel(8'(i * 31));
    settle(12);
    write_register(REG_ROW_COUNT, 13'd2);
    write_register(REG_COLUMN_COUNT, 13'd1);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'hFF : 8'h00);
    settle(12);
  endtask

  // a write part way through a frame restarts it; frames then wrap on their own
  task automatic test_restart();
    write_register(REG_ROW_COUNT, 13'd5);
    write_register(REG_COLUMN_COUNT, 13'd4);
    for (int i = 0; i < 7; i++) send_pixel(8'($urandom));
    settle(12);
    write_register(REG_COLUMN_COUNT, 13'd4);
    for (int i = 0; i < 60; i++) send_pixel(8'($urandom));
    settle(12);
  endtask

  // mostly whole frames of random size and content, some cut short
  task automatic test_random_frames();
    int unsigned sent, frame_len, cut, round;
    pix_style_t  style;
    logic [7:0]  base;
    sent = 0;
    round = 0;
    while (sent < 150 || round < 4) begin
      write_register(REG_ROW_COUNT, 13'($urandom_range(0, 6)));
      write_register(REG_COLUMN_COUNT, ($urandom_range(7) == 0) ?
                     13'($urandom_range(13, 24)) : 13'($urandom_range(0, 12)));
      frame_len = active_rows() * active_columns();
      cut = $urandom_range(1, 2) * frame_len;
      if ($urandom_range(5) == 0) cut = $urandom_range(1, frame_len - 1);
      style = pix_style_t'($urandom_range(2));
      base = 8'($urandom);
      calm = (round == 2);
      // the stretch with no idling is kept long
      if (calm && cut < 60) cut = 60;
      for (int i = 0; i < cut; i++) begin
        // hold off mid-frame until the output side has drained
        if (round == 3 && i == cut / 2) settle(0);
        send_pixel(pick_pixel(style, base));
      end
      calm = 1'b0;
      settle(12);
      sent += cut;
      round++;
    end
  endtask

  // sizes above the maximum clamped, paired with sizes below the minimum; only the start of each frame is sent
  task automatic test_large_frames();
    write_register(REG_ROW_COUNT, 13'h1FFF);
    write_register(REG_COLUMN_COUNT, 13'd0);
    for (int i = 0; i < 30; i++) send_pixel(8'($urandom));
    settle(12);
    write_register(REG_ROW_COUNT, 13'd1);
    write_register(REG_COLUMN_COUNT, 13'h7FF);
    for (int i = 0; i < 24; i++) send_pixel(8'($urandom));
    settle(12);
  endtask

  initial begin
    clear_filter();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_default_frame();
    test_small_frames();
    test_restart();
    test_random_frames();
    test_large_frames();
    settle(20);
    if (bad_pixels == 0 && due_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
